/* rtl/bvm_pkg.sv */
// Shared types and constants for the bit-vector approximate string matcher.
package bvm_pkg;

    localparam int WORD_BITS_DEF  = 64;
    localparam int MAX_BLOCKS_DEF = 4;
    localparam int ALPHABET       = 256;

    localparam int SYM_W      = 8;
    localparam int LEN_W      = 9;
    localparam int POS_W      = 32;
    localparam int SCORE_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE   = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [7:0]       pattern_index;
        logic [SYM_W-1:0] symbol;
        logic             first;
    } item_t;

    typedef struct packed {
        logic [LEN_W-1:0] distance;
        logic [POS_W-1:0] position;
    } result_t;

endpackage

/* rtl/bit_vector_approx_string_match.sv */
// Top level: pattern store, block state memory and the per-item sequencer.
//
// Usage: items arrive on the item channel (valid/ready). With mode 0 an item
// writes one pattern byte at pattern_index; it produces no result, and the
// sequencer reads the pattern row, writes it back and returns to idle. With
// mode 1 an item is a text byte; first restarts the search. Block state for
// each 64-row block sits in a RAM with registered read data; the sequencer
// reads one block a cycle, advances it with the carry from the block below
// and writes it back, then decides the band and the score. The sweep covers
// the active blocks plus one more when the band may grow. At most one result
// (distance, position) comes out per text byte, held in an output register
// until result_ready; the next item is taken while it waits, but a second
// result stalls the sequencer until the first is taken. Configuration
// (pattern_length, max_distance) is written through cfg_write by the user
// only while idle; the block does not enforce it. Reset clears control state
// and marks all block entries as holding their reset vectors; the pattern
// store holds garbage until written.
module bit_vector_approx_string_match #(
    parameter int WORD_BITS  = bvm_pkg::WORD_BITS_DEF,
    parameter int MAX_BLOCKS = bvm_pkg::MAX_BLOCKS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  bvm_pkg::item_t                      item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output bvm_pkg::result_t                    result,
    input  logic                                cfg_write,
    input  logic [bvm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bvm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import bvm_pkg::*;

    localparam int BW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int RW   = $clog2(WORD_BITS + 1);
    localparam int CW   = $clog2(WORD_BITS);
    localparam int VW   = 2 * WORD_BITS + SCORE_W;
    localparam int PW   = WORD_BITS * 8;
    localparam int CAP  = (WORD_BITS * MAX_BLOCKS < 256) ? WORD_BITS * MAX_BLOCKS : 256;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SWEEP = 3'd1;
    localparam logic [2:0] ST_FIN   = 3'd2;
    localparam logic [2:0] ST_PRD   = 3'd3;
    localparam logic [2:0] ST_PWR   = 3'd4;

    function automatic logic [7:0] sym_mod(input logic [7:0] s);
        logic [16:0] r;
        r = {9'd0, s};
        for (int i = 7; i >= 0; i--)
        begin
            if (r >= 17'(ALPHABET << i))
            begin
                r = r - 17'(ALPHABET << i);
            end
        end
        return r[7:0];
    endfunction

    function automatic logic [SCORE_W-1:0] sat16(input logic signed [19:0] v);
        if (v < 0)
        begin
            return '0;
        end
        else if (v > 20'sd65535)
        begin
            return '1;
        end
        return v[SCORE_W-1:0];
    endfunction

    // configuration
    logic [LEN_W-1:0] plen_reg;
    logic [LEN_W-1:0] kdist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg  <= LEN_W'(1);
            kdist_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PATTERN_LENGTH: plen_reg  <= cfg_data;
                CFG_MAX_DISTANCE:   kdist_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // derived from configuration
    logic [LEN_W-1:0] m_len;
    logic [BW-1:0]    last_blk;
    logic [BW-1:0]    ystart;
    logic [RW-1:0]    rows_last;

    always_comb
    begin
        if (plen_reg == '0)
        begin
            m_len = LEN_W'(1);
        end
        else if (int'(plen_reg) > CAP)
        begin
            m_len = LEN_W'(CAP);
        end
        else
        begin
            m_len = plen_reg;
        end
        last_blk = '0;
        ystart   = '0;
        for (int b = 1; b < MAX_BLOCKS; b++)
        begin
            if (b * WORD_BITS < int'(m_len))
            begin
                last_blk = BW'(b);
            end
            if (b * WORD_BITS < int'(kdist_reg))
            begin
                ystart = BW'(b);
            end
        end
        if (ystart > last_blk)
        begin
            ystart = last_blk;
        end
        rows_last = RW'(int'(m_len) - int'(last_blk) * WORD_BITS);
    end

    // sequencer registers
    logic [2:0]            state_reg, state_next;
    logic [7:0]            sym_reg, sym_next;
    logic                  first_reg, first_next;
    logic [BW-1:0]         y_reg, y_next;
    logic [BW-1:0]         rd_end_reg, rd_end_next;
    logic                  ext_ok_reg, ext_ok_next;
    logic [BW-1:0]         rd_idx_reg, rd_idx_next;
    logic                  rd_more_reg, rd_more_next;
    logic                  pr_vld_reg, pr_vld_next;
    logic [BW-1:0]         pr_idx_reg, pr_idx_next;
    logic signed [1:0]     carry_reg, carry_next;
    logic [SCORE_W-1:0]    score_y_reg, score_y_next;
    logic                  ext_hit_reg, ext_hit_next;
    logic [SCORE_W-1:0]    ext_score_reg, ext_score_next;
    logic [MAX_BLOCKS-1:0] flags_reg, flags_next;
    logic [MAX_BLOCKS-1:0] valid_reg, valid_next;
    logic [BW-1:0]         top_reg, top_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [POS_W-1:0]      pos_out_reg, pos_out_next;
    logic [BW-1:0]         prow_reg, prow_next;
    logic [CW-1:0]         pbyte_reg, pbyte_next;
    logic                  result_valid_reg, result_valid_next;
    result_t               result_reg, result_next;

    // memories
    logic          pram_we;
    logic [BW-1:0] pram_raddr;
    logic [PW-1:0] pram_wdata;
    logic [PW-1:0] pram_rdata;
    logic          vram_we;
    logic [VW-1:0] vram_wdata;
    logic [VW-1:0] vram_rdata;

    bvm_ram #(.WIDTH(PW), .DEPTH(MAX_BLOCKS)) u_pattern_ram (
        .clk   (clk),
        .we    (pram_we),
        .waddr (prow_reg),
        .wdata (pram_wdata),
        .raddr (pram_raddr),
        .rdata (pram_rdata)
    );

    bvm_ram #(.WIDTH(VW), .DEPTH(MAX_BLOCKS)) u_block_ram (
        .clk   (clk),
        .we    (vram_we),
        .waddr (pr_idx_reg),
        .wdata (vram_wdata),
        .raddr (rd_idx_reg),
        .rdata (vram_rdata)
    );

    // block datapath
    logic                  is_ext;
    logic                  use_init;
    logic [WORD_BITS-1:0]  cur_pv;
    logic [WORD_BITS-1:0]  cur_mv;
    logic [SCORE_W-1:0]    cur_score;
    logic [RW-1:0]         rows_cur;
    logic [WORD_BITS-1:0]  adv_pv;
    logic [WORD_BITS-1:0]  adv_mv;
    logic signed [1:0]     adv_h;
    logic                  adv_eq0;
    logic [SCORE_W-1:0]    new_score;
    logic signed [19:0]    sum_n;
    logic signed [19:0]    sum_e;
    logic signed [19:0]    band_gap;
    logic                  ext_cond;

    always_comb
    begin
        is_ext   = ext_ok_reg && (pr_idx_reg > y_reg);
        use_init = first_reg || is_ext;
        rows_cur = (pr_idx_reg == last_blk) ? rows_last : RW'(WORD_BITS);
        if (use_init)
        begin
            cur_pv    = '1;
            cur_mv    = '0;
            cur_score = (pr_idx_reg == last_blk) ? SCORE_W'(m_len)
                                                 : SCORE_W'((int'(pr_idx_reg) + 1) * WORD_BITS);
        end
        else if (valid_reg[pr_idx_reg])
        begin
            cur_pv    = vram_rdata[WORD_BITS-1:0];
            cur_mv    = vram_rdata[2*WORD_BITS-1:WORD_BITS];
            cur_score = vram_rdata[VW-1:2*WORD_BITS];
        end
        else
        begin
            cur_pv    = '1;
            cur_mv    = '0;
            cur_score = SCORE_W'((int'(pr_idx_reg) + 1) * WORD_BITS);
        end
    end

    bvm_advance #(.WORD_BITS(WORD_BITS)) u_advance (
        .pv       (cur_pv),
        .mv       (cur_mv),
        .pat_row  (pram_rdata),
        .sym      (sym_reg),
        .rows     (rows_cur),
        .hin      (carry_reg),
        .pv_next  (adv_pv),
        .mv_next  (adv_mv),
        .hout     (adv_h),
        .eq_first (adv_eq0)
    );

    always_comb
    begin
        sum_n     = $signed({4'b0000, cur_score}) + 20'(adv_h);
        new_score = sat16(sum_n);
        sum_e     = $signed({4'b0000, score_y_reg} + 20'(rows_cur) - 20'(carry_reg)
                            + 20'(adv_h));
        band_gap  = $signed({4'b0000, score_y_reg}) - 20'(carry_reg);
        ext_cond  = (band_gap <= $signed({11'd0, kdist_reg})) &&
                    (adv_eq0 || (carry_reg < 0));
    end

    // band shrink and report
    logic [BW-1:0]      y_shrink;
    logic [BW-1:0]      y_final;
    logic [SCORE_W-1:0] score_final;
    logic               emit;
    logic               fin_go;

    always_comb
    begin
        y_shrink = '0;
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            if ((BW'(i) <= y_reg) && ((i == 0) || !flags_reg[i]))
            begin
                y_shrink = BW'(i);
            end
        end
        y_final     = ext_hit_reg ? BW'(y_reg + BW'(1)) : y_shrink;
        score_final = ext_hit_reg ? ext_score_reg : score_y_reg;
        emit        = (y_final == last_blk) &&
                      (17'(score_final) <= 17'(kdist_reg));
        fin_go      = !emit || !result_valid_reg || result_ready;
    end

    // accept-time values
    logic [BW-1:0] y_acc;
    logic [BW-1:0] prow_acc;
    logic          prow_ok;

    always_comb
    begin
        y_acc = item.first ? ystart : top_reg;
        if (y_acc > last_blk)
        begin
            y_acc = last_blk;
        end
        prow_acc = '0;
        for (int b = 1; b < MAX_BLOCKS; b++)
        begin
            if (int'(item.pattern_index) >= b * WORD_BITS)
            begin
                prow_acc = BW'(b);
            end
        end
        prow_ok = int'(item.pattern_index) < MAX_BLOCKS * WORD_BITS;
    end

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign pram_raddr   = (state_reg == ST_SWEEP) ? rd_idx_reg : prow_reg;

    always_comb
    begin
        pram_wdata = pram_rdata;
        pram_wdata[int'(pbyte_reg)*8 +: 8] = sym_reg;
    end

    always_comb
    begin
        state_next        = state_reg;
        sym_next          = sym_reg;
        first_next        = first_reg;
        y_next            = y_reg;
        rd_end_next       = rd_end_reg;
        ext_ok_next       = ext_ok_reg;
        rd_idx_next       = rd_idx_reg;
        rd_more_next      = rd_more_reg;
        pr_vld_next       = 1'b0;
        pr_idx_next       = pr_idx_reg;
        carry_next        = carry_reg;
        score_y_next      = score_y_reg;
        ext_hit_next      = ext_hit_reg;
        ext_score_next    = ext_score_reg;
        flags_next        = flags_reg;
        valid_next        = valid_reg;
        top_next          = top_reg;
        pos_next          = pos_reg;
        pos_out_next      = pos_out_reg;
        prow_next         = prow_reg;
        pbyte_next        = pbyte_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        pram_we           = 1'b0;
        vram_we           = 1'b0;
        vram_wdata        = {new_score, adv_mv, adv_pv};

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    sym_next = sym_mod(item.symbol);
                    if (item.mode)
                    begin
                        first_next   = item.first;
                        y_next       = y_acc;
                        ext_ok_next  = y_acc < last_blk;
                        rd_end_next  = (y_acc < last_blk) ? BW'(y_acc + BW'(1)) : y_acc;
                        rd_idx_next  = '0;
                        rd_more_next = 1'b1;
                        carry_next   = 2'sd0;
                        ext_hit_next = 1'b0;
                        pos_out_next = item.first ? '0 : pos_reg;
                        pos_next     = item.first ? POS_W'(1)
                                     : ((pos_reg == '1) ? pos_reg : pos_reg + POS_W'(1));
                        state_next   = ST_SWEEP;
                    end
                    else if (prow_ok)
                    begin
                        prow_next  = prow_acc;
                        pbyte_next = CW'(int'(item.pattern_index)
                                         - int'(prow_acc) * WORD_BITS);
                        state_next = ST_PRD;
                    end
                end
            end
            ST_SWEEP:
            begin
                // issue the next block read while the previous one is updated
                pr_vld_next  = rd_more_reg;
                pr_idx_next  = rd_idx_reg;
                rd_idx_next  = BW'(rd_idx_reg + BW'(1));
                rd_more_next = rd_more_reg && (rd_idx_reg != rd_end_reg);
                if (pr_vld_reg)
                begin
                    if (is_ext)
                    begin
                        if (ext_cond)
                        begin
                            vram_we        = 1'b1;
                            vram_wdata     = {sat16(sum_e), adv_mv, adv_pv};
                            valid_next[pr_idx_reg] = 1'b1;
                            ext_hit_next   = 1'b1;
                            ext_score_next = sat16(sum_e);
                        end
                    end
                    else
                    begin
                        vram_we    = 1'b1;
                        valid_next[pr_idx_reg] = 1'b1;
                        carry_next = adv_h;
                        flags_next[pr_idx_reg] = 17'(new_score) >=
                                                 17'(kdist_reg) + 17'(WORD_BITS);
                        if (pr_idx_reg == y_reg)
                        begin
                            score_y_next = new_score;
                        end
                    end
                    if (pr_idx_reg == rd_end_reg)
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    top_next   = y_final;
                    state_next = ST_IDLE;
                    if (emit)
                    begin
                        result_valid_next    = 1'b1;
                        result_next.distance = score_final[LEN_W-1:0];
                        result_next.position = pos_out_reg;
                    end
                end
            end
            ST_PRD:
            begin
                state_next = ST_PWR;
            end
            ST_PWR:
            begin
                pram_we    = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            rd_more_reg      <= 1'b0;
            pr_vld_reg       <= 1'b0;
            valid_reg        <= '0;
            top_reg          <= '0;
            pos_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rd_more_reg      <= rd_more_next;
            pr_vld_reg       <= pr_vld_next;
            valid_reg        <= valid_next;
            top_reg          <= top_next;
            pos_reg          <= pos_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg       <= sym_next;
        first_reg     <= first_next;
        y_reg         <= y_next;
        rd_end_reg    <= rd_end_next;
        ext_ok_reg    <= ext_ok_next;
        rd_idx_reg    <= rd_idx_next;
        pr_idx_reg    <= pr_idx_next;
        carry_reg     <= carry_next;
        score_y_reg   <= score_y_next;
        ext_hit_reg   <= ext_hit_next;
        ext_score_reg <= ext_score_next;
        flags_reg     <= flags_next;
        pos_out_reg   <= pos_out_next;
        prow_reg      <= prow_next;
        pbyte_reg     <= pbyte_next;
        result_reg    <= result_next;
    end

    a_vram_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        vram_we |-> (state_reg == ST_SWEEP) && pr_vld_reg)
        else $error("block RAM written outside a sweep");

    a_pram_in_write: assert property (@(posedge clk) disable iff (!rst_n)
        pram_we |-> $past(state_reg) == ST_PRD)
        else $error("pattern RAM written without a prior row read");

    a_proc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) && pr_vld_reg |-> pr_idx_reg <= rd_end_reg)
        else $error("block processed past the end of the band");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg) == ST_FIN)
        else $error("result raised outside the finish step");

    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) && !fin_go |=> state_reg == ST_FIN)
        else $error("finish step left while the output is blocked");

endmodule

/* rtl/bvm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bvm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/bvm_advance.sv */
// One block step of the column update: match mask and delta-vector advance.
module bvm_advance #(
    parameter int WORD_BITS = 64
) (
    input  logic [WORD_BITS-1:0]                 pv,
    input  logic [WORD_BITS-1:0]                 mv,
    input  logic [WORD_BITS*8-1:0]               pat_row,
    input  logic [7:0]                           sym,
    input  logic [$clog2(WORD_BITS+1)-1:0]       rows,
    input  logic signed [1:0]                    hin,
    output logic [WORD_BITS-1:0]                 pv_next,
    output logic [WORD_BITS-1:0]                 mv_next,
    output logic signed [1:0]                    hout,
    output logic                                 eq_first
);

    localparam int RW = $clog2(WORD_BITS + 1);
    localparam int CW = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] eq;
    logic [WORD_BITS-1:0] eq_h;
    logic [WORD_BITS-1:0] xv;
    logic [WORD_BITS-1:0] xh;
    logic [WORD_BITS-1:0] ph;
    logic [WORD_BITS-1:0] mh;
    logic [WORD_BITS-1:0] ph_s;
    logic [WORD_BITS-1:0] mh_s;
    logic [CW-1:0]        ob;

    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            eq[j] = (pat_row[j*8 +: 8] == sym) && (RW'(j) < rows);
        end
    end

    assign eq_first = eq[0];
    assign ob       = CW'(rows - RW'(1));

    always_comb
    begin
        xv   = eq | mv;
        eq_h = eq | {{(WORD_BITS-1){1'b0}}, hin[1]};
        xh   = (((eq_h & pv) + pv) ^ pv) | eq_h;
        ph   = mv | ~(xh | pv);
        mh   = pv & xh;
        case ({ph[ob], mh[ob]})
            2'b10:   hout = 2'sd1;
            2'b01:   hout = -2'sd1;
            default: hout = 2'sd0;
        endcase
        ph_s = {ph[WORD_BITS-2:0], 1'b0};
        mh_s = {mh[WORD_BITS-2:0], 1'b0};
        // feed the horizontal delta from the block below into row zero
        if (hin < 0)
        begin
            mh_s[0] = 1'b1;
        end
        else if (hin > 0)
        begin
            ph_s[0] = 1'b1;
        end
        pv_next = mh_s | ~(xv | ph_s);
        mv_next = ph_s & xv;
    end

endmodule

/* sim/bit_vector_approx_string_match_tb.sv */
// Self-checking testbench for the bit-vector approximate string matcher.
module bit_vector_approx_string_match_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bvm_pkg::*;

    localparam int WB        = 64;
    localparam int NB        = 4;
    localparam int LIMIT     = 600000;
    localparam int SETTLE    = 16;

    typedef enum logic { MODE_PATTERN = 1'b0, MODE_TEXT = 1'b1 } mode_e;

    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_ready;
    item_t                 item;
    logic                  result_valid;
    logic                  result_ready;
    result_t               result;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bit_vector_approx_string_match u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // matcher mirror state
    logic [7:0]  pat_mem [256];
    logic [63:0] plus_v  [NB];
    logic [63:0] minus_v [NB];
    int          score   [NB];
    int          top_blk;
    logic [31:0] text_pos;
    int          len_reg;
    int          dist_reg;

    item_t   pending_items [$];
    result_t match_q       [$];
    int      errors;
    int      cycles;
    int      gap_left;
    int      burst_left;
    int      stall_bits;
    logic [7:0] gen_pat [256];

    function automatic int sat16(int v);
        if (v < 0) return 0;
        if (v > 65535) return 65535;
        return v;
    endfunction

    function automatic int rows_in(int b, int m);
        return ((b + 1) * WB <= m) ? WB : m - b * WB;
    endfunction

    function automatic logic [63:0] match_bits(int b, logic [7:0] c, int m);
        logic [63:0] r;
        int pos;
        r = '0;
        for (int j = 0; j < WB; j++)
        begin
            pos = b * WB + j;
            if (pos < m && pos < 256 && pat_mem[pos] == c)
                r[j] = 1'b1;
        end
        return r;
    endfunction

    function automatic void reset_block(int b, int m);
        plus_v[b]  = '1;
        minus_v[b] = '0;
        score[b]   = sat16(b * WB + rows_in(b, m));
    endfunction

    // advance one block; return the horizontal delta at row outbit
    function automatic int advance_block(int b, logic [63:0] eq_in, int hin, int outbit);
        logic [63:0] pv, mv, eq, xv, xh, ph, mh;
        int hout;
        pv = plus_v[b];
        mv = minus_v[b];
        eq = eq_in;
        hout = 0;
        xv = eq | mv;
        if (hin < 0) eq[0] = 1'b1;
        xh = (((eq & pv) + pv) ^ pv) | eq;
        ph = mv | ~(xh | pv);
        mh = pv & xh;
        if (ph[outbit]) hout += 1;
        if (mh[outbit]) hout -= 1;
        ph = ph << 1;
        mh = mh << 1;
        if (hin < 0) mh[0] = 1'b1;
        else if (hin > 0) ph[0] = 1'b1;
        plus_v[b]  = mh | ~(xv | ph);
        minus_v[b] = ph & xv;
        return hout;
    endfunction

    function automatic void predict_match(item_t it);
        int m, last, y, carry, h;
        logic [31:0] pos;
        logic [63:0] eq_up;
        result_t r;
        if (it.mode == MODE_PATTERN)
        begin
            pat_mem[it.pattern_index] = it.symbol;
            return;
        end
        m = len_reg;
        if (m < 1) m = 1;
        if (m > 256) m = 256;
        last = (m - 1) / WB;
        carry = 0;
        if (it.first)
        begin
            y = (dist_reg == 0) ? 0 : (dist_reg + WB - 1) / WB - 1;
            if (y > last) y = last;
            for (int b = 0; b <= y; b++) reset_block(b, m);
            top_blk = y;
            text_pos = '0;
        end
        if (top_blk > last) top_blk = last;
        y = top_blk;
        for (int b = 0; b <= y; b++)
        begin
            carry = advance_block(b, match_bits(b, it.symbol, m), carry, rows_in(b, m) - 1);
            score[b] = sat16(score[b] + carry);
        end
        eq_up = match_bits(y + 1, it.symbol, m);
        if (y < last && score[y] - carry <= dist_reg && (eq_up[0] || carry < 0))
        begin
            y++;
            reset_block(y, m);
            h = advance_block(y, match_bits(y, it.symbol, m), carry, rows_in(y, m) - 1);
            score[y] = sat16(score[y - 1] + rows_in(y, m) - carry + h);
        end
        else
        begin
            while (y > 0 && score[y] >= dist_reg + WB) y--;
        end
        top_blk = y;
        pos = text_pos;
        if (text_pos != 32'hFFFF_FFFF) text_pos++;
        if (y == last && score[y] <= dist_reg)
        begin
            r.distance = score[y][8:0];
            r.position = pos;
            match_q.push_back(r);
        end
    endfunction

    // driver: bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
            gap_left   <= 0;
            burst_left <= 0;
        end
        else
        begin
            if (item_valid && item_ready)
                predict_match(item);
            if (!item_valid || item_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left   <= gap_left - 1;
                    item_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    item       <= pending_items.pop_front();
                    item_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            stall_bits   <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (match_q.size() == 0)
                begin
                    $display("%0t: unexpected transaction distance=%0d position=%0d",
                             $time, result.distance, result.position);
                    errors++;
                end
                else
                begin
                    result_t exp_r;
                    exp_r = match_q.pop_front();
                    if (result.distance !== exp_r.distance)
                    begin
                        $display("%0t: distance expected %0d actual %0d",
                                 $time, exp_r.distance, result.distance);
                        errors++;
                    end
                    if (result.position !== exp_r.position)
                    begin
                        $display("%0t: position expected %0d actual %0d",
                                 $time, exp_r.position, result.position);
                        errors++;
                    end
                end
            end
            // rotate a 16-bit ready pattern; reload it now and then
            if ($urandom_range(0, 31) == 0)
                stall_bits <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : $urandom_range(0, 65535);
            else
                stall_bits <= {stall_bits[14:0], stall_bits[15]};
            result_ready <= stall_bits[15] | (stall_bits == 0);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic void push_item(mode_e md, int idx, int sym, bit fst);
        item_t it;
        it.mode          = md;
        it.pattern_index = idx[7:0];
        it.symbol        = sym[7:0];
        it.first         = fst;
        pending_items.push_back(it);
        if (md == MODE_PATTERN) gen_pat[idx[7:0]] = sym[7:0];
    endfunction

    task automatic wait_idle();
        while (pending_items.size() != 0 || match_q.size() != 0 || item_valid)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_PATTERN_LENGTH) len_reg = val;
        else dist_reg = val;
    endtask

    // text: copies of the pattern with edits, some noise and pattern rewrites
    task automatic run_phase(int len, int maxd, int n_text, int sym_max, bit restart);
        int sent, plen, start, kind;
        bit fst;
        wait_idle();
        write_reg(CFG_PATTERN_LENGTH, len);
        write_reg(CFG_MAX_DISTANCE, maxd);
        for (int i = 0; i < len; i++)
            if ($urandom_range(0, 1)) push_item(MODE_PATTERN, i, $urandom_range(0, sym_max),
                                                $urandom_range(0, 1));
        sent = 0;
        fst  = restart;
        while (sent < n_text)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                push_item(MODE_PATTERN, $urandom_range(0, 255), $urandom_range(0, sym_max),
                          $urandom_range(0, 1));
            end
            else if (kind == 1)
            begin
                push_item(MODE_TEXT, $urandom_range(0, 255), $urandom_range(0, 255), fst);
                fst = 0;
                sent++;
            end
            else
            begin
                if ($urandom_range(0, 3) == 0) fst = 1;
                plen  = (len > 40) ? $urandom_range(len - 8, len) : len;
                start = len - plen;
                for (int i = start; i < len && sent < n_text; i++)
                begin
                    case ($urandom_range(0, 11))
                        0: ;
                        1: begin
                            push_item(MODE_TEXT, $urandom, $urandom_range(0, sym_max), fst);
                            fst = 0;
                            sent++;
                        end
                        2: begin
                            push_item(MODE_TEXT, $urandom, $urandom_range(0, sym_max), fst);
                            push_item(MODE_TEXT, $urandom, gen_pat[i], 0);
                            fst = 0;
                            sent += 2;
                        end
                        default: begin
                            push_item(MODE_TEXT, $urandom, gen_pat[i], fst);
                            fst = 0;
                            sent++;
                        end
                    endcase
                end
            end
        end
    endtask

    initial
    begin
        errors     = 0;
        cycles     = 0;
        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = CFG_PATTERN_LENGTH;
        cfg_data   = '0;
        len_reg    = 1;
        dist_reg   = 0;
        top_blk    = 0;
        text_pos   = '0;
        for (int b = 0; b < NB; b++)
        begin
            plus_v[b]  = '1;
            minus_v[b] = '0;
            score[b]   = (b + 1) * WB;
        end
        for (int i = 0; i < 256; i++)
        begin
            pat_mem[i] = '0;
            gen_pat[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset config, text before any restart, symbol extremes
        push_item(MODE_PATTERN, 0, 8'hFF, 1);
        push_item(MODE_TEXT, 8'hFF, 8'hFF, 0);
        push_item(MODE_TEXT, 0, 8'h00, 0);
        push_item(MODE_PATTERN, 255, 8'h00, 0);
        push_item(MODE_TEXT, 8'hAA, 8'hFF, 1);
        push_item(MODE_TEXT, 8'h55, 8'hFF, 0);
        push_item(MODE_PATTERN, 0, 8'h00, 0);
        push_item(MODE_TEXT, 0, 8'h00, 0);
        push_item(MODE_TEXT, 8'hFF, 8'h80, 1);
        // load the whole store so that no unwritten entry is ever read
        for (int i = 1; i < 256; i++)
            push_item(MODE_PATTERN, i, $urandom_range(0, 3), 0);

        run_phase(256, 256, 24,  3,   1);
        run_phase(1,   0,   24,  1,   1);
        run_phase(64,  3,   70,  3,   1);
        run_phase(65,  1,   70,  3,   1);
        run_phase(130, 64,  56,  7,   1);
        run_phase(200, 12,  70,  3,   0);
        run_phase(17,  4,   56,  255, 1);
        run_phase(256, 0,   48,  1,   1);
        run_phase(100, 130, 48,  3,   1);
        run_phase(192, 65,  56,  3,   1);
        run_phase(5,   256, 24,  255, 0);

        wait_idle();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* bit_vector_approx_string_match.f */
rtl/bvm_pkg.sv
rtl/bvm_ram.sv
rtl/bvm_advance.sv
rtl/bit_vector_approx_string_match.sv
sim/bit_vector_approx_string_match_tb.sv
